// ===== sv/mx44_pkg.sv =====
// Shared types for the matrix unit: operation codes and the pipeline tag
// that travels from the sequencer to the datapath. No dependencies.
`default_nettype none

package mx44_pkg;

   typedef enum logic [1:0] {
      OP_MUL   = 2'd0,
      OP_ADD   = 2'd1,
      OP_SUB   = 2'd2,
      OP_SCALE = 2'd3
   } op_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

endpackage

`default_nettype wire

// ===== sv/mx44_store.sv =====
// Element memories for matrices A and B: one write port for loading and one
// registered read port each. Depends on nothing but its parameter.
`default_nettype none

module mx44_store #(
   parameter int DIM = 4
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(DIM*DIM)-1:0]        wr_addr,
   input  wire logic [31:0]                       wr_a,
   input  wire logic [31:0]                       wr_b,
   input  wire logic [$clog2(DIM*DIM)-1:0]        a_addr,
   input  wire logic [$clog2(DIM*DIM)-1:0]        b_addr,
   output logic signed [31:0]                     rd_a,
   output logic signed [31:0]                     rd_b
);

   localparam int NELEM = DIM * DIM;

   logic [31:0] a_mem [NELEM];
   logic [31:0] b_mem [NELEM];
   logic signed [31:0] rd_a_ff;
   logic signed [31:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         a_mem[wr_addr] <= wr_a;
         b_mem[wr_addr] <= wr_b;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= $signed(a_mem[a_addr]);
      rd_b_ff <= $signed(b_mem[b_addr]);
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== sv/mx44_sequencer.sv =====
// Load counter and run sequencer: walks elements and dot-product terms and
// issues store addresses with a pipeline tag. Depends on mx44_pkg.
`default_nettype none

module mx44_sequencer #(
   parameter int DIM = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [1:0]                        action,
   input  wire logic                              run_done,
   output logic                                   busy,
   output logic                                   wr_en,
   output logic [$clog2(DIM*DIM)-1:0]             wr_addr,
   output logic [$clog2(DIM*DIM)-1:0]             a_addr,
   output logic [$clog2(DIM*DIM)-1:0]             b_addr,
   output mx44_pkg::tag_type                      tag,
   output mx44_pkg::op_type                       op
);

   import mx44_pkg::*;

   localparam int NELEM = DIM * DIM;
   localparam int AW = $clog2(NELEM);
   localparam int CW = $clog2(DIM);

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] load_count_ff, load_count_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] k_ff, k_in;
   op_type        op_ff, op_in;
   logic [AW-1:0] a_addr_ff, a_addr_in;
   logic [AW-1:0] b_addr_ff, b_addr_in;
   tag_type       tag_ff, tag_in;

   logic          accept;
   logic          term_last;
   logic          row_last;
   logic          col_last;
   logic [AW-1:0] elem_addr;

   assign accept    = start && (state_ff == ST_LOAD);
   assign row_last  = (row_ff == CW'(DIM - 1));
   assign col_last  = (col_ff == CW'(DIM - 1));
   assign term_last = (op_ff != OP_MUL) || (k_ff == CW'(DIM - 1));
   assign elem_addr = AW'(row_ff) + AW'(col_ff) * AW'(DIM);

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      k_in          = k_ff;
      op_in         = op_ff;
      a_addr_in     = a_addr_ff;
      b_addr_in     = b_addr_ff;
      tag_in        = '0;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (load_count_ff == AW'(NELEM - 1)) begin
                  load_count_in = '0;
                  op_in         = op_type'(action);
                  state_in      = ST_ISSUE;
               end else begin
                  load_count_in = load_count_ff + 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            case (op_ff)
               OP_MUL: begin
                  a_addr_in = AW'(row_ff) + AW'(k_ff) * AW'(DIM);
                  b_addr_in = AW'(k_ff) + AW'(col_ff) * AW'(DIM);
               end
               OP_SCALE: begin
                  a_addr_in = elem_addr;
                  b_addr_in = '0;
               end
               default: begin
                  a_addr_in = elem_addr;
                  b_addr_in = elem_addr;
               end
            endcase
            tag_in.valid = 1'b1;
            tag_in.first = (op_ff != OP_MUL) || (k_ff == '0);
            tag_in.last  = term_last;
            if (!term_last) begin
               k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (!row_last) begin
                  row_in = row_ff + 1'b1;
               end else begin
                  row_in = '0;
                  if (!col_last) begin
                     col_in = col_ff + 1'b1;
                  end else begin
                     col_in   = '0;
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (run_done) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         k_ff          <= '0;
         op_ff         <= OP_MUL;
         tag_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         k_ff          <= k_in;
         op_ff         <= op_in;
         tag_ff        <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
   end

   assign busy    = (state_ff != ST_LOAD);
   assign wr_en   = accept;
   assign wr_addr = load_count_ff;
   assign a_addr  = a_addr_ff;
   assign b_addr  = b_addr_ff;
   assign tag     = tag_ff;
   assign op      = op_ff;

endmodule

`default_nettype wire

// ===== sv/mx44_datapath.sv =====
// Shared arithmetic unit: one signed multiplier or adder, accumulator,
// rounding and saturation, and the result register. Depends on mx44_pkg.
`default_nettype none

module mx44_datapath #(
   parameter int DIM = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  mx44_pkg::op_type           op,
   input  mx44_pkg::tag_type          tag,
   input  wire logic signed [31:0]    rd_a,
   input  wire logic signed [31:0]    rd_b,
   output logic                       rsp_valid,
   output logic signed [31:0]         rsp_result_elem,
   output logic [3:0]                 rsp_elem_index,
   output logic                       rsp_last_result,
   output logic                       rsp_saturated
);

   import mx44_pkg::*;

   localparam int NELEM = DIM * DIM;
   localparam int AW = $clog2(NELEM);
   localparam int ACW = 64 + $clog2(DIM);
   localparam logic signed [ACW-1:0] HALF = {{(ACW-16){1'b0}}, 16'h8000};
   localparam logic signed [ACW-1:0] MAXV = {{(ACW-32){1'b0}}, 32'h7FFF_FFFF};
   localparam logic signed [ACW-1:0] MINV = {{(ACW-32){1'b1}}, 32'h8000_0000};

   tag_type              tag1_ff, tag2_ff, tag3_ff;
   logic signed [63:0]   prod_ff, prod_in;
   logic signed [63:0]   mul_res;
   logic signed [63:0]   a_ext, b_ext;
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic signed [ACW-1:0] prod_wide;
   logic signed [ACW-1:0] rnd_ff, rnd_in;
   logic                 rnd_valid_ff;
   logic [AW-1:0]        rnd_idx_ff;
   logic [AW-1:0]        out_idx_ff;
   logic                 do_round;
   logic [AW+3:0]        idx_wide;
   logic                 rsp_valid_ff;
   logic signed [31:0]   rsp_result_ff, sat_val;
   logic [3:0]           rsp_index_ff;
   logic                 rsp_last_ff, rsp_sat_ff, sat_flag, idx_last;

   assign a_ext   = {{32{rd_a[31]}}, rd_a};
   assign b_ext   = {{32{rd_b[31]}}, rd_b};
   assign mul_res = rd_a * rd_b;

   always_comb begin
      case (op)
         OP_ADD:  prod_in = a_ext + b_ext;
         OP_SUB:  prod_in = a_ext - b_ext;
         default: prod_in = mul_res;
      endcase
   end

   assign prod_wide = {{(ACW-64){prod_ff[63]}}, prod_ff};
   assign acc_in    = tag2_ff.first ? prod_wide : acc_ff + prod_wide;
   assign do_round  = (op == OP_MUL) || (op == OP_SCALE);
   assign rnd_in    = do_round ? ((acc_ff + HALF) >>> 16) : acc_ff;
   assign idx_last  = (rnd_idx_ff == AW'(NELEM - 1));
   assign idx_wide  = {4'b0000, rnd_idx_ff};

   always_comb begin
      sat_flag = 1'b0;
      sat_val  = rnd_ff[31:0];
      if (rnd_ff > MAXV) begin
         sat_flag = 1'b1;
         sat_val  = 32'sh7FFF_FFFF;
      end else if (rnd_ff < MINV) begin
         sat_flag = 1'b1;
         sat_val  = -32'sh8000_0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         rnd_valid_ff <= 1'b0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag1_ff      <= tag;
         tag2_ff      <= tag1_ff;
         tag3_ff      <= tag2_ff;
         rnd_valid_ff <= tag3_ff.valid && tag3_ff.last;
         if (tag3_ff.valid && tag3_ff.last) begin
            out_idx_ff <= (out_idx_ff == AW'(NELEM - 1)) ? '0 : out_idx_ff + 1'b1;
         end
         rsp_valid_ff <= rnd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tag1_ff.valid) begin
         prod_ff <= prod_in;
      end
      if (tag2_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (tag3_ff.valid && tag3_ff.last) begin
         rnd_ff     <= rnd_in;
         rnd_idx_ff <= out_idx_ff;
      end
      rsp_result_ff <= sat_val;
      rsp_index_ff  <= idx_wide[3:0];
      rsp_last_ff   <= idx_last;
      rsp_sat_ff    <= sat_flag;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_elem = rsp_result_ff;
   assign rsp_elem_index  = rsp_index_ff;
   assign rsp_last_result = rsp_valid_ff && rsp_last_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

`default_nettype wire

// ===== sv/matrix4x4_alu_top.sv =====
// Top level of the fixed-point matrix unit: store, sequencer and shared
// datapath. Depends on mx44_pkg, mx44_store, mx44_sequencer, mx44_datapath.
`default_nettype none

// The unit takes DIM*DIM words, one per cycle while busy is low, each with
// one column-major element of A and of B in signed Q16.16; action is taken
// from the word that completes the set. Busy then rises and the unit issues
// one term per cycle to its single multiplier-adder: DIM*DIM*DIM terms for
// the product and DIM*DIM for add, subtract or scale. Results come out
// column-major, each on rsp_valid for one cycle, and must be taken when
// shown since there is no back-pressure. Busy falls in the cycle after the
// last result.
module matrix4x4_alu_top #(
   parameter int DIM = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [31:0] req_a_elem,
   input  wire logic signed [31:0] req_b_elem,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_result_elem,
   output logic [3:0]              rsp_elem_index,
   output logic                    rsp_last_result,
   output logic                    rsp_saturated
);

   import mx44_pkg::*;

   localparam int AW = $clog2(DIM * DIM);

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      a_addr;
   logic [AW-1:0]      b_addr;
   logic signed [31:0] rd_a;
   logic signed [31:0] rd_b;
   tag_type            tag;
   op_type             op;

   mx44_sequencer #(.DIM(DIM)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .action   (req_action),
      .run_done (rsp_last_result),
      .busy     (busy),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .a_addr   (a_addr),
      .b_addr   (b_addr),
      .tag      (tag),
      .op       (op)
   );

   mx44_store #(.DIM(DIM)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_a    (req_a_elem),
      .wr_b    (req_b_elem),
      .a_addr  (a_addr),
      .b_addr  (b_addr),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   mx44_datapath #(.DIM(DIM)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .tag             (tag),
      .rd_a            (rd_a),
      .rd_b            (rd_b),
      .rsp_valid       (rsp_valid),
      .rsp_result_elem (rsp_result_elem),
      .rsp_elem_index  (rsp_elem_index),
      .rsp_last_result (rsp_last_result),
      .rsp_saturated   (rsp_saturated)
   );

`ifndef NO_ASSERTIONS
   a_no_result_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_valid)
      else $error("Result word shown while the unit is idle.");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_last_result |=> !busy)
      else $error("Unit still busy after the last result word.");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("Busy rose without an accepted input word.");
`endif

endmodule

`default_nettype wire

// ===== bench/matrix4x4_alu_top_test.sv =====
// Self-checking bench for matrix4x4_alu_top: loads sets of sixteen words and checks every
// result element against an in-bench model of the four matrix operations.
// Depends on mx44_pkg and the matrix4x4_alu_top RTL.
module matrix4x4_alu_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mx44_pkg::*;

   localparam int DIM = 4;
   localparam int NELEM = DIM * DIM;
   localparam int RANDOM_SETS = 24;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 16;
   localparam logic signed [31:0] Q_TOP = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_BOTTOM = 32'sh8000_0000;
   localparam logic signed [67:0] WIDE_TOP = 68'sh7FFF_FFFF;
   localparam logic signed [67:0] WIDE_BOTTOM = -68'sh8000_0000;

   typedef struct {
      op_type            action;
      logic signed [31:0] a;
      logic signed [31:0] b;
      int unsigned       gap;
      bit                drain;
   } word_type;

   typedef struct {
      logic signed [31:0] value;
      logic [3:0]         index;
      logic               last;
      logic               sat;
   } elem_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_action = '0;
   logic signed [31:0] req_a_elem = '0;
   logic signed [31:0] req_b_elem = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_result_elem;
   logic [3:0] rsp_elem_index;
   logic rsp_last_result;
   logic rsp_saturated;

   word_type pending_words[$];
   elem_type expected_elems[$];
   logic signed [31:0] a_words[NELEM];
   logic signed [31:0] b_words[NELEM];
   int fill_count = 0;
   int op_count[4] = '{0, 0, 0, 0};
   int words_taken = 0;
   int elems_checked = 0;
   int elems_clamped = 0;
   int drain_pauses = 0;
   int failures = 0;
   int quiet_cycles = 0;
   bit took = 1'b0;
   bit item_live = 1'b0;
   bit gap_armed = 1'b0;
   int unsigned gap_left = 0;
   word_type current;
   elem_type want;

   matrix4x4_alu_top #(.DIM(DIM)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_a_elem(req_a_elem),
      .req_b_elem(req_b_elem),
      .rsp_valid(rsp_valid),
      .rsp_result_elem(rsp_result_elem),
      .rsp_elem_index(rsp_elem_index),
      .rsp_last_result(rsp_last_result),
      .rsp_saturated(rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic signed [31:0] pick_elem();
      case ($urandom_range(0, 9))
         0: return Q_TOP;
         1: return Q_BOTTOM;
         2, 3: return $urandom;
         default: return $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
      endcase
   endfunction

   task automatic queue_set(input op_type op, input logic signed [31:0] a_set[NELEM],
                            input logic signed [31:0] b_set[NELEM], input bit drain);
      word_type w;
      bit burst;
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < NELEM; i++) begin
         w.action = (i == NELEM - 1) ? op : op_type'($urandom_range(0, 3));
         w.a = a_set[i];
         w.b = b_set[i];
         w.gap = burst ? 0 : $urandom_range(0, 11);
         w.drain = drain && (i == 0);
         pending_words.push_back(w);
      end
   endtask

   task automatic take_word(input logic [1:0] action, input logic signed [31:0] a,
                            input logic signed [31:0] b);
      logic signed [67:0] acc;
      logic signed [67:0] val;
      elem_type e;
      int row;
      int col;
      a_words[fill_count] = a;
      b_words[fill_count] = b;
      fill_count++;
      if (fill_count == NELEM) begin
         fill_count = 0;
         op_count[action]++;
         for (int i = 0; i < NELEM; i++) begin
            row = i % DIM;
            col = i / DIM;
            case (op_type'(action))
               OP_MUL: begin
                  acc = '0;
                  for (int k = 0; k < DIM; k++)
                     acc = acc + a_words[row + DIM * k] * b_words[k + DIM * col];
                  val = (acc + 68'sd32768) >>> 16;
               end
               OP_ADD: val = a_words[i] + b_words[i];
               OP_SUB: val = a_words[i] - b_words[i];
               default: val = (a_words[i] * b_words[0] + 68'sd32768) >>> 16;
            endcase
            e.sat = 1'b1;
            if (val > WIDE_TOP) begin
               e.value = Q_TOP;
            end else if (val < WIDE_BOTTOM) begin
               e.value = Q_BOTTOM;
            end else begin
               e.value = val[31:0];
               e.sat = 1'b0;
            end
            e.index = 4'(i);
            e.last = (i == NELEM - 1);
            expected_elems.push_back(e);
         end
      end
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (start && took)
            item_live = 1'b0;
         if (!item_live && pending_words.size() != 0) begin
            if (pending_words[0].drain && expected_elems.size() != 0) begin
               if (!gap_armed)
                  drain_pauses += (gap_left == 0) ? 0 : 0;
            end else begin
               if (!gap_armed) begin
                  gap_left = pending_words[0].gap;
                  gap_armed = 1'b1;
               end
               if (gap_left == 0) begin
                  current = pending_words.pop_front();
                  if (current.drain)
                     drain_pauses++;
                  gap_armed = 1'b0;
                  item_live = 1'b1;
                  req_action <= current.action;
                  req_a_elem <= current.a;
                  req_b_elem <= current.b;
               end else begin
                  gap_left--;
               end
            end
         end
         start <= item_live;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         took = 1'b0;
         quiet_cycles = 0;
      end else begin
         took = start && !busy;
         if (took) begin
            words_taken++;
            take_word(req_action, req_a_elem, req_b_elem);
         end
         if (rsp_valid) begin
            if (expected_elems.size() == 0) begin
               $error("unexpected result element at index %0d", rsp_elem_index);
               failures++;
            end else begin
               want = expected_elems.pop_front();
               elems_checked++;
               if (want.sat)
                  elems_clamped++;
               if (rsp_result_elem !== want.value) begin
                  $error("result_elem: expected %h, got %h", want.value, rsp_result_elem);
                  failures++;
               end
               if (rsp_elem_index !== want.index) begin
                  $error("elem_index: expected %0d, got %0d", want.index, rsp_elem_index);
                  failures++;
               end
               if (rsp_last_result !== want.last) begin
                  $error("last_result: expected %b, got %b", want.last, rsp_last_result);
                  failures++;
               end
               if (rsp_saturated !== want.sat) begin
                  $error("saturated: expected %b, got %b", want.sat, rsp_saturated);
                  failures++;
               end
            end
         end
         if (took || rsp_valid)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timed out after %0d cycles without a handshake.", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      logic signed [31:0] a_set[NELEM];
      logic signed [31:0] b_set[NELEM];
      logic signed [31:0] b_alt[NELEM];
      logic signed [31:0] row_pick[DIM];
      logic signed [31:0] col_pick[DIM];
      logic signed [31:0] col_alt[DIM];
      row_pick = '{Q_TOP, Q_BOTTOM, 32'sh0001_8000, -32'sd1};
      col_pick = '{Q_TOP, Q_BOTTOM, 32'sh0000_8000, 32'sd0};
      col_alt = '{32'sh0000_8000, Q_TOP, Q_BOTTOM, 32'sd0};
      for (int i = 0; i < NELEM; i++) begin
         a_set[i] = row_pick[i % DIM];
         b_set[i] = col_pick[i / DIM];
         b_alt[i] = col_alt[i / DIM];
      end
      queue_set(OP_MUL, a_set, b_set, 1'b0);
      queue_set(OP_ADD, a_set, b_set, 1'b1);
      queue_set(OP_SUB, a_set, b_set, 1'b0);
      queue_set(OP_SCALE, a_set, b_alt, 1'b0);
      for (int s = 0; s < RANDOM_SETS; s++) begin
         for (int i = 0; i < NELEM; i++) begin
            a_set[i] = pick_elem();
            b_set[i] = pick_elem();
         end
         queue_set(op_type'($urandom_range(0, 3)), a_set, b_set,
                   (s == 0) || ($urandom_range(0, 5) == 0));
      end

      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || item_live || expected_elems.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Loaded %0d words in %0d sets: %0d multiply, %0d add, %0d subtract, %0d scale.",
               words_taken, words_taken / NELEM, op_count[OP_MUL], op_count[OP_ADD],
               op_count[OP_SUB], op_count[OP_SCALE]);
      $display("Checked %0d result elements, %0d clamped, with %0d drained pauses.",
               elems_checked, elems_clamped, drain_pauses);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== matrix4x4_alu_top.f =====
sv/mx44_pkg.sv
sv/mx44_store.sv
sv/mx44_sequencer.sv
sv/mx44_datapath.sv
sv/matrix4x4_alu_top.sv
bench/matrix4x4_alu_top_test.sv
